@@ hdl/eatht_pkg.sv @@
`default_nettype none
package eatht_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngW        = 28;
  localparam int unsigned XyW         = 34;
  localparam int unsigned TrigW       = 16;
  localparam int unsigned ShiftW      = 32;

  localparam logic signed [AngW-1:0] AngPi     = 28'sd52707179;
  localparam logic signed [AngW-1:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [XyW-1:0]  CordicGain = 34'sd652032874;
  localparam int OneQ14 = 16384;

  // Arctangent of 2^-i, radians in Q.24.
  function automatic logic signed [AngW-1:0] atan_q24(input logic [3:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      4'd0:  r = 28'sd13176795;
      4'd1:  r = 28'sd7778716;
      4'd2:  r = 28'sd4110060;
      4'd3:  r = 28'sd2086331;
      4'd4:  r = 28'sd1047214;
      4'd5:  r = 28'sd524117;
      4'd6:  r = 28'sd262123;
      4'd7:  r = 28'sd131069;
      4'd8:  r = 28'sd65536;
      4'd9:  r = 28'sd32768;
      4'd10: r = 28'sd16384;
      4'd11: r = 28'sd8192;
      4'd12: r = 28'sd4096;
      4'd13: r = 28'sd2048;
      4'd14: r = 28'sd1024;
      default: r = 28'sd512;
    endcase
    return r;
  endfunction

  // Round-half-up shift of a wide product, then clamp to plus or minus one.
  function automatic logic signed [TrigW-1:0] round_clamp(input logic signed [63:0] v,
                                                          input int unsigned s);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (s - 1))) >>> s;
    if (t > 64'sd16384) t = 64'sd16384;
    else if (t < -64'sd16384) t = -64'sd16384;
    return t[TrigW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/euler_angles_to_homogeneous_transform_core.sv @@
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | roll, pitch, yaw angles, shift x/y/z
// out     | output    | out_valid / out_stall | r00..r22, col3 x/y/z
// One pose enters every cycle while in_stall is low; the pipeline is the 16-stage
// CORDIC plus fold, sign, rounding, two multiply stages and the output
// rounding stage.
// The whole pipeline advances together; out_stall freezes every stage while the last stage holds a result.
// in_stall follows out_stall only when the last stage holds a result.
// Reset clears the valid bits only.
module euler_angles_to_homogeneous_transform_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] roll_angle_i,
  input  wire logic signed [15:0] pitch_angle_i,
  input  wire logic signed [15:0] yaw_angle_i,
  input  wire logic signed [31:0] shift_x_i,
  input  wire logic signed [31:0] shift_y_i,
  input  wire logic signed [31:0] shift_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0] r00_o, r01_o, r02_o,
  output logic signed [15:0] r10_o, r11_o, r12_o,
  output logic signed [15:0] r20_o, r21_o, r22_o,
  output logic signed [31:0] col3_x_o,
  output logic signed [31:0] col3_y_o,
  output logic signed [31:0] col3_z_o
);
  import eatht_pkg::*;

  localparam int unsigned TrigLat = CordicSteps + 3;
  localparam int unsigned Lat     = TrigLat + 3;

  logic adv;
  logic [Lat-1:0] vld_q;
  logic signed [TrigW-1:0] sr, cr, sp, cp, sy, cy;
  logic signed [ShiftW-1:0] tx_q [Lat], ty_q [Lat], tz_q [Lat];

  assign adv        = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !adv;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q[0] <= shift_x_i; ty_q[0] <= shift_y_i; tz_q[0] <= shift_z_i;
      for (int i = 1; i < Lat; i++) begin
        tx_q[i] <= tx_q[i-1]; ty_q[i] <= ty_q[i-1]; tz_q[i] <= tz_q[i-1];
      end
    end
  end

  eatht_cordic u_roll  (.clk_i, .adv_i(adv), .angle_i(roll_angle_i),
                        .sin_o(sr), .cos_o(cr));
  eatht_cordic u_pitch (.clk_i, .adv_i(adv), .angle_i(pitch_angle_i),
                        .sin_o(sp), .cos_o(cp));
  eatht_cordic u_yaw   (.clk_i, .adv_i(adv), .angle_i(yaw_angle_i),
                        .sin_o(sy), .cos_o(cy));

  // First multiply stage: all two-factor products in Q.28.
  logic signed [31:0] cysp_q, sysp_q, sycr_q, sysr_q, cycr_q, cysr_q;
  logic signed [31:0] cycp_q, sycp_q, cpsr_q, cpcr_q;
  logic signed [TrigW-1:0] sr_q, cr_q, sp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cysp_q <= cy * sp; sysp_q <= sy * sp;
      sycr_q <= sy * cr; sysr_q <= sy * sr;
      cycr_q <= cy * cr; cysr_q <= cy * sr;
      cycp_q <= cy * cp; sycp_q <= sy * cp;
      cpsr_q <= cp * sr; cpcr_q <= cp * cr;
      sr_q <= sr; cr_q <= cr; sp_q <= sp;
    end
  end

  // Second multiply stage: three-factor terms in Q.42, plus rounding of the two-factor entries.
  logic signed [63:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [TrigW-1:0] r00_q, r10_q, r20_q, r21_q, r22_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t01_q <= 64'(cysp_q) * 64'(sr_q) - (64'(sycr_q) <<< 14);
      t02_q <= 64'(cysp_q) * 64'(cr_q) + (64'(sysr_q) <<< 14);
      t11_q <= 64'(sysp_q) * 64'(sr_q) + (64'(cycr_q) <<< 14);
      t12_q <= 64'(sysp_q) * 64'(cr_q) - (64'(cysr_q) <<< 14);
      r00_q <= round_clamp(64'(cycp_q), 14);
      r10_q <= round_clamp(64'(sycp_q), 14);
      // Sine is already within plus or minus one, so its negation needs no clamp.
      r20_q <= -sp_q;
      r21_q <= round_clamp(64'(cpsr_q), 14);
      r22_q <= round_clamp(64'(cpcr_q), 14);
    end
  end

  // Output register: rounding of the three-factor entries.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r01_o <= round_clamp(t01_q, 28); r02_o <= round_clamp(t02_q, 28);
      r11_o <= round_clamp(t11_q, 28); r12_o <= round_clamp(t12_q, 28);
      r00_o <= r00_q; r10_o <= r10_q; r21_o <= r21_q; r22_o <= r22_q;
      r20_o <= r20_q;
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign col3_x_o = tx_q[Lat-1];
  assign col3_y_o = ty_q[Lat-1];
  assign col3_z_o = tz_q[Lat-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r00_o) && $stable(col3_x_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> r00_o <= 16'sd16384 && r00_o >= -16'sd16384)
    else $error("rotation entry beyond one");
endmodule
`default_nettype wire

@@ hdl/eatht_cordic.sv @@
`default_nettype none
module eatht_cordic (
  input  wire logic                                clk_i,
  input  wire logic                                adv_i,
  input  wire logic signed [15:0]                  angle_i,
  output logic signed [eatht_pkg::TrigW-1:0]       sin_o,
  output logic signed [eatht_pkg::TrigW-1:0]       cos_o
);
  import eatht_pkg::*;

  logic signed [XyW-1:0]  x_q [CordicSteps+1];
  logic signed [XyW-1:0]  y_q [CordicSteps+1];
  logic signed [AngW-1:0] z_q [CordicSteps+1];
  logic                   f_q [CordicSteps+1];
  logic signed [XyW-1:0]  xo_q, yo_q;
  logic signed [AngW-1:0] z_in;

  // Fold into plus or minus pi/2 at entry.
  always_comb begin
    z_in = AngW'(angle_i) <<< 11;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      if (z_in > AngHalfPi) begin
        z_q[0] <= z_in - AngPi; f_q[0] <= 1'b1;
      end else if (z_in < -AngHalfPi) begin
        z_q[0] <= z_in + AngPi; f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z_in; f_q[0] <= 1'b0;
      end
    end
  end

  // One registered rotation step per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        f_q[i+1] <= f_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q24(4'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q24(4'(i));
        end
      end
    end
  end

  // Sign fix, then rounding and clamp in the next stage.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xo_q  <= f_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
      yo_q  <= f_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];
      cos_o <= round_clamp(64'(xo_q), 16);
      sin_o <= round_clamp(64'(yo_q), 16);
    end
  end

endmodule
`default_nettype wire
